/* src/ppq_pkg.sv */
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and codes for the pending packet hold queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ppq_pkg;

  localparam int CAPACITY = 64;
  localparam int AddrW    = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);

  // input modes
  localparam logic [2:0] ModeEnq     = 3'd0;
  localparam logic [2:0] ModeRelFlow = 3'd1;
  localparam logic [2:0] ModeDrpFlow = 3'd2;
  localparam logic [2:0] ModeDrpDev  = 3'd3;
  localparam logic [2:0] ModeFlush   = 3'd4;

  // verdicts
  localparam logic [1:0] VerNone    = 2'd0;
  localparam logic [1:0] VerAccept  = 2'd1;
  localparam logic [1:0] VerDrop    = 2'd2;
  localparam logic [1:0] VerDropIcmp = 2'd3;

  // result status
  localparam logic [2:0] StEnqueued = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StClosed   = 3'd2;
  localparam logic [2:0] StRemoved  = 3'd3;
  localparam logic [2:0] StNoMatch  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CfgMaxLen = 2'd0;
  localparam logic [1:0] CfgClosed = 2'd1;

  typedef struct packed {
    logic [15:0] pkt;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  tos;
    logic        flow_vld;
    logic [15:0] in_dev;
    logic [15:0] out_dev;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start_imm;   // enqueue or unknown mode, answered at once
    logic start_scan;  // removal item begins
    logic scanning;
    logic finish;
  } ppq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } ppq_sts_t;

endpackage

`default_nettype wire

/* src/ppq_ctrl.sv */
// ----------------------------------------------------------------------------
// ppq_ctrl
// Item sequencer: idle, or scanning the queue for a removal item.
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_ctrl
  import ppq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [2:0] mode_i,
  input  wire ppq_sts_t   sts_i,
  output ppq_cmd_t        cmd_o,
  output logic            busy_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;
  logic accept, is_scan_mode;

  assign accept       = start_i && (state_q == StIdle);
  assign is_scan_mode = (mode_i >= ModeRelFlow) && (mode_i <= ModeFlush);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && is_scan_mode) state_d = StScan;
      StScan: if (sts_i.scan_done) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.start_imm  = accept && !is_scan_mode;
  assign cmd_o.start_scan = accept && is_scan_mode;
  assign cmd_o.scanning   = (state_q == StScan);
  assign cmd_o.finish     = (state_q == StScan) && sts_i.scan_done;
  assign busy_o           = (state_q != StIdle);

endmodule

`default_nettype wire

/* src/ppq_dpath.sv */
// ----------------------------------------------------------------------------
// ppq_dpath
// Entry memory, config registers, scan/compaction logic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_dpath
  import ppq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ppq_cmd_t    cmd_i,
  output ppq_sts_t         sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [15:0] packet_id_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [7:0]  tos_byte_i,
  input  wire logic        has_flow_info_i,
  input  wire logic [15:0] in_ifindex_i,
  input  wire logic [15:0] out_ifindex_i,
  input  wire logic [15:0] query_ifindex_i,
  output logic             result_valid_o,
  output logic [15:0]      out_packet_id_o,
  output logic [1:0]       verdict_o,
  output logic [2:0]       status_o,
  output logic [6:0]       queue_len_o,
  output logic             last_o
);

  entry_t mem [CAPACITY];
  entry_t rd_data_q;

  logic [6:0]      max_len_q;
  logic            closed_q;
  logic [CntW-1:0] count_q, rd_idx_q, keep_q, remain_q;
  logic            vld_q;
  logic [2:0]      qmode_q;
  logic [31:0]     qsrc_q, qdst_q;
  logic [7:0]      qtos_q;
  logic [15:0]     qdev_q;
  logic [1:0]      scan_ver_q;
  logic            pend_vld_q;
  logic [15:0]     pend_pkt_q;
  logic [CntW-1:0] pend_len_q;

  logic            res_vld_q;
  logic [15:0]     res_pkt_q;
  logic [1:0]      res_ver_q;
  logic [2:0]      res_st_q;
  logic [CntW-1:0] res_len_q;
  logic            res_last_q;

  logic            rd_en, hit, full, wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t          wr_data;

  assign rd_en = cmd_i.scanning && (rd_idx_q != count_q);
  assign sts_o.scan_done = (rd_idx_q == count_q) && !vld_q;

  always_comb begin
    hit = 1'b0;
    case (qmode_q) inside
      ModeRelFlow, ModeDrpFlow:
        hit = rd_data_q.flow_vld && (rd_data_q.src == qsrc_q) &&
              (rd_data_q.dst == qdst_q) && (rd_data_q.tos == qtos_q);
      ModeDrpDev:
        hit = ((rd_data_q.in_dev != 16'd0) && (rd_data_q.in_dev == qdev_q)) ||
              ((rd_data_q.out_dev != 16'd0) && (rd_data_q.out_dev == qdev_q));
      ModeFlush: hit = 1'b1;
      default:   hit = 1'b0;
    endcase
  end

  assign full = (count_q >= max_len_q) || (count_q >= CntW'(CAPACITY));

  // one write port: enqueue append, or compaction of a kept entry
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AddrW-1:0];
    wr_data = '{pkt: packet_id_i, src: src_addr_i, dst: dst_addr_i, tos: tos_byte_i,
                flow_vld: has_flow_info_i, in_dev: in_ifindex_i,
                out_dev: out_ifindex_i};
    if (cmd_i.start_imm && (mode_i == ModeEnq) && !full && !closed_q) begin
      wr_en = 1'b1;
    end else if (vld_q && !hit) begin
      wr_en   = 1'b1;
      wr_addr = keep_q[AddrW-1:0];
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_idx_q[AddrW-1:0]];
  end

  // query capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      qmode_q    <= mode_i;
      qsrc_q     <= src_addr_i;
      qdst_q     <= dst_addr_i;
      qtos_q     <= tos_byte_i;
      qdev_q     <= query_ifindex_i;
      scan_ver_q <= (mode_i == ModeRelFlow) ? VerAccept :
                    (mode_i == ModeDrpFlow) ? VerDropIcmp : VerDrop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= 7'(CAPACITY);
      closed_q   <= 1'b0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      keep_q     <= '0;
      remain_q   <= '0;
      vld_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_pkt_q <= '0;
      pend_len_q <= '0;
      res_vld_q  <= 1'b0;
      res_pkt_q  <= '0;
      res_ver_q  <= VerNone;
      res_st_q   <= StNoMatch;
      res_len_q  <= '0;
      res_last_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      vld_q     <= rd_en;
      if (rd_en) rd_idx_q <= rd_idx_q + CntW'(1);

      if (cfg_we_i) begin
        if (cfg_index_i == CfgMaxLen) max_len_q <= cfg_data_i;
        else if (cfg_index_i == CfgClosed) closed_q <= cfg_data_i[0];
      end

      if (cmd_i.start_imm) begin
        res_vld_q  <= 1'b1;
        res_last_q <= 1'b1;
        res_len_q  <= count_q;
        res_pkt_q  <= packet_id_i;
        if (mode_i != ModeEnq) begin
          res_pkt_q <= '0;
          res_ver_q <= VerNone;
          res_st_q  <= StNoMatch;
        end else if (full) begin
          res_ver_q <= VerDrop;
          res_st_q  <= StFull;
        end else if (closed_q) begin
          res_ver_q <= VerDrop;
          res_st_q  <= StClosed;
        end else begin
          count_q   <= count_q + CntW'(1);
          res_len_q <= count_q + CntW'(1);
          res_ver_q <= VerNone;
          res_st_q  <= StEnqueued;
        end
      end

      if (cmd_i.start_scan) begin
        rd_idx_q   <= '0;
        keep_q     <= '0;
        remain_q   <= count_q;
        pend_vld_q <= 1'b0;
      end

      if (vld_q) begin
        if (hit) begin
          // flush the older hit; hold this one until we know if it is last
          if (pend_vld_q) begin
            res_vld_q  <= 1'b1;
            res_pkt_q  <= pend_pkt_q;
            res_ver_q  <= scan_ver_q;
            res_st_q   <= StRemoved;
            res_len_q  <= pend_len_q;
            res_last_q <= 1'b0;
          end
          pend_vld_q <= 1'b1;
          pend_pkt_q <= rd_data_q.pkt;
          pend_len_q <= remain_q - CntW'(1);
          remain_q   <= remain_q - CntW'(1);
        end else begin
          keep_q <= keep_q + CntW'(1);
        end
      end

      if (cmd_i.finish) begin
        count_q    <= keep_q;
        res_vld_q  <= 1'b1;
        res_last_q <= 1'b1;
        if (pend_vld_q) begin
          res_pkt_q <= pend_pkt_q;
          res_ver_q <= scan_ver_q;
          res_st_q  <= StRemoved;
          res_len_q <= pend_len_q;
        end else begin
          res_pkt_q <= '0;
          res_ver_q <= VerNone;
          res_st_q  <= StNoMatch;
          res_len_q <= keep_q;
        end
      end
    end
  end

  assign result_valid_o  = res_vld_q;
  assign out_packet_id_o = res_pkt_q;
  assign verdict_o       = res_ver_q;
  assign status_o        = res_st_q;
  assign queue_len_o     = 7'(res_len_q);
  assign last_o          = res_last_q;

endmodule

`default_nettype wire

/* src/pending_packet_hold_queue_top.sv */
// ----------------------------------------------------------------------------
// pending_packet_hold_queue_top
// Hold queue for packets waiting on a route, with flow/device matched release.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start_i is high and busy_o is low.
//   Results come out on result_valid_o, one cycle each; last_o marks the
//   final result of an item. The receiver cannot stall the block.
//   Enqueue and unknown modes: one result, the cycle after start; busy_o
//   never rises, so a new item may follow at once.
//   Release/drop/flush: the single memory read port walks the N held entries
//   one per cycle, compacting kept ones in place; busy_o stays high while
//   it scans. Each hit is reported once the next hit is found, the final
//   one at the end; the last result shows in the same cycle busy_o falls,
//   when the next item can start.
//   Config channel: cfg_ready_o is always high; the user must write only
//   while idle; the block does not check. Index 0 is max_len, index 1 is
//   closed; other indexes are ignored. Reset empties the queue, sets max_len
//   to 64 and opens the queue. The entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_packet_hold_queue_top
  import ppq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [15:0] packet_id_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [7:0]  tos_byte_i,
  input  wire logic        has_flow_info_i,
  input  wire logic [15:0] in_ifindex_i,
  input  wire logic [15:0] out_ifindex_i,
  input  wire logic [15:0] query_ifindex_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  output logic             result_valid_o,
  output logic [15:0]      out_packet_id_o,
  output logic [1:0]       verdict_o,
  output logic [2:0]       status_o,
  output logic [6:0]       queue_len_o,
  output logic             last_o
);

  ppq_cmd_t cmd;
  ppq_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ppq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ppq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (mode_i),
    .packet_id_i     (packet_id_i),
    .src_addr_i      (src_addr_i),
    .dst_addr_i      (dst_addr_i),
    .tos_byte_i      (tos_byte_i),
    .has_flow_info_i (has_flow_info_i),
    .in_ifindex_i    (in_ifindex_i),
    .out_ifindex_i   (out_ifindex_i),
    .query_ifindex_i (query_ifindex_i),
    .result_valid_o  (result_valid_o),
    .out_packet_id_o (out_packet_id_o),
    .verdict_o       (verdict_o),
    .status_o        (status_o),
    .queue_len_o     (queue_len_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

/* src/ppq_checker.sv */
// ----------------------------------------------------------------------------
// ppq_checker
// Port-level checks on the hold queue's command and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_checker
  import ppq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [2:0]  mode_i,
  input wire logic        result_valid_o,
  input wire logic [15:0] out_packet_id_o,
  input wire logic [1:0]  verdict_o,
  input wire logic [2:0]  status_o,
  input wire logic [6:0]  queue_len_o,
  input wire logic        last_o
);

  // a result needs an item in flight or just taken
  a_res_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o || start_i))
    else $error("result beat without an item");

  // enqueue answers in the next cycle with a final beat
  a_enq_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == ModeEnq)) |=> (result_valid_o && last_o))
    else $error("enqueue result missing");

  a_enq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == StEnqueued)) |-> (verdict_o == VerNone &&
      queue_len_o != 7'd0))
    else $error("bad enqueued beat");

  a_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == StNoMatch)) |-> (last_o &&
      out_packet_id_o == 16'd0 && verdict_o == VerNone))
    else $error("bad nothing-matched beat");

endmodule

bind pending_packet_hold_queue_top ppq_checker u_ppq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .mode_i          (mode_i),
  .result_valid_o  (result_valid_o),
  .out_packet_id_o (out_packet_id_o),
  .verdict_o       (verdict_o),
  .status_o        (status_o),
  .queue_len_o     (queue_len_o),
  .last_o          (last_o)
);

`default_nettype wire
